// ===== rtl/sdf_pkg.sv =====
package sdf_pkg;

    localparam int DIGITS = 5;
    localparam int MAG_W  = 17;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DIGITS - 1);
    localparam logic [2:0]       MAX_FLEN  = 3'(DIGITS);
    localparam logic [1:0]       MAX_PLACE = 2'd2;

    localparam logic [6:0] CH_MINUS = 7'd45;
    localparam logic [6:0] CH_POINT = 7'd46;
    localparam logic [6:0] CH_ZERO  = 7'd48;

    typedef struct packed {
        logic signed [15:0] value;
        logic [2:0]         field_length;
        logic [1:0]         decimal_places;
    } t_in;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
    } t_out;

endpackage

// ===== rtl/sdf_bcd.sv =====
// Shift-and-add-3 converter: one magnitude bit enters the BCD register per cycle.
module sdf_bcd
    import sdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [MAG_W-1:0] i_mag,
    output logic             o_done,
    output logic [BCD_W-1:0] o_bcd
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] n_adj;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            n_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                         : r_bcd[4*k +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_bin <= i_mag;
                r_bcd <= '0;
                r_cnt <= CNT_W'(MAG_W);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_bcd <= {n_adj[BCD_W-2:0], r_bin[MAG_W-1]};
                r_bin <= {r_bin[MAG_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== rtl/signed_int_decimal_formatter.sv =====
// Channel   Handshake                  Payload
// input     start in, busy out         i_item   (t_in: value, field_length, decimal_places)
// result    o_strobe, one cycle each   o_result (t_out: char_code, last)
//
// An item is accepted when start is high and busy is low. Its magnitude is
// converted to five BCD digits by a shift-and-add-3 unit that takes one bit
// per cycle, and when conversion is done the digits are handed over for
// output. Characters then leave one per cycle, 1 to 7 of them, and busy
// stays high from acceptance until the last character goes out, so the next
// item can be accepted at the end of the cycle in which the last character
// is shown. Reset is synchronous and active low and returns the block to
// idle. The receiver cannot stall; each character is valid for one cycle.
module signed_int_decimal_formatter
    import sdf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    t_state r_state;

    // Item settings held for the whole run.
    logic             r_neg;
    logic [2:0]       r_flen;
    logic [1:0]       r_places;

    // Emission progress: pending sign, point already sent, digit index.
    logic             r_sign;
    logic             r_dot;
    logic [IDX_W-1:0] r_idx;

    logic             r_strobe;
    t_out             r_result;

    logic             w_load;
    logic [MAG_W-1:0] w_mag;
    logic [MAG_W-1:0] w_ext;
    logic             w_done;
    logic [BCD_W-1:0] w_bcd;

    logic [IDX_W-1:0] w_stop;
    logic [IDX_W-1:0] w_first;
    logic [IDX_W-1:0] w_begin;
    logic [3:0]       w_digit;
    t_out             n_result;
    logic             n_sign;
    logic             n_dot;
    logic [IDX_W-1:0] n_idx;

    assign w_load = start && (r_state == ST_IDLE);

    // Magnitude in 17 bits so that the most negative value stays exact.
    assign w_ext = {i_item.value[15], i_item.value};
    assign w_mag = i_item.value[15] ? (MAG_W'(0) - w_ext) : w_ext;

    sdf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_mag   (w_mag),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    // First fraction digit sits at five minus the number of places.
    assign w_stop = IDX_W'(DIGITS) - IDX_W'(r_places);

    // Start digit: fixed by the field length, or the first nonzero digit
    // when the field length is zero, never later than the units digit.
    always_comb begin
        if (r_flen != 3'd0) begin
            w_first = IDX_W'(DIGITS) - r_flen;
        end else begin
            priority if (w_bcd[BCD_W-1 -: 4] != 4'd0) begin
                w_first = IDX_W'(0);
            end else if (w_bcd[BCD_W-5 -: 4] != 4'd0) begin
                w_first = IDX_W'(1);
            end else if (w_bcd[BCD_W-9 -: 4] != 4'd0) begin
                w_first = IDX_W'(2);
            end else if (w_bcd[BCD_W-13 -: 4] != 4'd0) begin
                w_first = IDX_W'(3);
            end else begin
                w_first = LAST_IDX;
            end
        end
    end

    // When the start lies past the point, the run begins at the point.
    assign w_begin = (w_first < w_stop) ? w_first : w_stop;

    // Digit index 0 is the most significant of the five.
    always_comb begin
        unique case (r_idx)
            IDX_W'(0): w_digit = w_bcd[19:16];
            IDX_W'(1): w_digit = w_bcd[15:12];
            IDX_W'(2): w_digit = w_bcd[11:8];
            IDX_W'(3): w_digit = w_bcd[7:4];
            IDX_W'(4): w_digit = w_bcd[3:0];
            default:   w_digit = 4'd0;
        endcase
    end

    // Next character of the run. The sign and the point are never last,
    // since digits always follow them.
    always_comb begin
        n_sign = r_sign;
        n_dot  = r_dot;
        n_idx  = r_idx;
        priority if (r_sign) begin
            n_result.char_code = CH_MINUS;
            n_result.last      = 1'b0;
            n_sign             = 1'b0;
        end else if ((r_idx == w_stop) && !r_dot && (r_places != 2'd0)) begin
            n_result.char_code = CH_POINT;
            n_result.last      = 1'b0;
            n_dot              = 1'b1;
        end else begin
            n_result.char_code = CH_ZERO + 7'(w_digit);
            n_result.last      = (r_idx == LAST_IDX);
            n_idx              = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_strobe <= 1'b0;
                    if (start) begin
                        r_neg    <= i_item.value[15];
                        r_flen   <= (i_item.field_length > MAX_FLEN) ? MAX_FLEN
                                                                     : i_item.field_length;
                        r_places <= (i_item.decimal_places > MAX_PLACE) ? MAX_PLACE
                                                                        : i_item.decimal_places;
                        r_state  <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_strobe <= 1'b0;
                    if (w_done) begin
                        r_idx   <= w_begin;
                        r_sign  <= r_neg;
                        r_dot   <= 1'b0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_strobe <= 1'b1;
                    r_result <= n_result;
                    r_sign   <= n_sign;
                    r_dot    <= n_dot;
                    r_idx    <= n_idx;
                    if (n_result.last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== bench/tb_signed_int_decimal_formatter.sv =====
`timescale 1ns / 1ps

// Testbench for the signed decimal formatter. Each value item sent to the
// block becomes a run of ASCII characters. The bench works out that run
// itself and checks every character the block shows against it, in order.
module tb_signed_int_decimal_formatter;
    import sdf_pkg::*;

    // The limit is many times what a correct run of a couple of hundred items
    // needs, even with the slowest items and the slowest sender phase.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASE  = 67;
    localparam int TABLE_ROWS    = 22;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic start    = 1'b0;
    t_in  i_item   = '0;
    logic busy;
    logic o_strobe;
    t_out o_result;

    // Characters still owed by the block, oldest first.
    t_out expected_chars [$];
    int   mismatch_count   = 0;
    int   cycle_count      = 0;
    int   sender_idle_pct  = 0;

    signed_int_decimal_formatter u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Directed table. Where a text is typed in, that text is the expected
    // run; an empty text means the row is checked against the predictor.
    // The rows cover zero, both extremes, every field length and decimal
    // place count including the out-of-range codes, suppressed leading
    // zeros that leave no integer digits, digits dropped above the field,
    // and a field that starts at or past the point.
    t_in table_item [TABLE_ROWS] = '{
        '{16'(0),      3'd0, 2'd0},
        '{16'(0),      3'd5, 2'd2},
        '{16'(32767),  3'd0, 2'd0},
        '{16'(-32768), 3'd0, 2'd0},
        '{16'(-32768), 3'd5, 2'd2},
        '{16'(5),      3'd0, 2'd2},
        '{16'(-1),     3'd0, 2'd1},
        '{16'(12345),  3'd3, 2'd0},
        '{16'(12345),  3'd1, 2'd2},
        '{16'(123),    3'd7, 2'd0},
        '{16'(123),    3'd6, 2'd1},
        '{16'(123),    3'd0, 2'd3},
        '{16'(-32768), 3'd7, 2'd3},
        '{16'(32767),  3'd2, 2'd2},
        '{16'(-1),     3'd5, 2'd2},
        '{16'(100),    3'd4, 2'd1},
        '{16'(-999),   3'd0, 2'd2},
        '{16'(1000),   3'd2, 2'd0},
        '{16'(-7),     3'd3, 2'd1},
        '{16'(9),      3'd0, 2'd0},
        '{16'(-10000), 3'd0, 2'd0},
        '{16'(-32767), 3'd1, 2'd3}
    };

    string table_text [TABLE_ROWS] = '{
        "0", "000.00", "32767", "-32768", "-327.68", ".05", "-.1", "345",
        ".45", "00123", "0012.3", "1.23", "-327.68", ".67", "-000.01",
        "", "", "", "", "", "", ""
    };

    // Appends one run of codes to the expectations, with last marking the
    // final character of the run.
    function automatic void queue_run(input logic [6:0] codes [$]);
        t_out ch;
        for (int k = 0; k < codes.size(); k++) begin
            ch.char_code = codes[k];
            ch.last      = (k == codes.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic void queue_text(input string text);
        logic [6:0] codes [$];
        for (int k = 0; k < text.len(); k++) begin
            codes.push_back(7'(text[k]));
        end
        queue_run(codes);
    endfunction

    // Predictor: the characters one value item must produce.
    function automatic void format_chars(input t_in item);
        logic [16:0] mag;
        logic        neg;
        int          digit [DIGITS];
        int          flen;
        int          places;
        int          first;
        int          point;
        logic [6:0]  codes [$];

        neg = item.value[15];
        // The magnitude has a 17th bit so that -32768 comes out as 32768.
        mag = neg ? (17'h10000 - {1'b0, item.value}) : {1'b0, item.value};
        for (int k = DIGITS - 1; k >= 0; k--) begin
            digit[k] = int'(mag % 17'd10);
            mag      = mag / 17'd10;
        end

        // Field lengths past five and a place count of three saturate.
        flen   = (item.field_length > MAX_FLEN) ? DIGITS : int'(item.field_length);
        places = (item.decimal_places > MAX_PLACE) ? int'(MAX_PLACE)
                                                   : int'(item.decimal_places);

        // Field length zero drops leading zeros, but always keeps the
        // ones digit so that zero still prints as a single digit.
        if (flen == 0) begin
            first = 0;
            while (first < DIGITS - 1 && digit[first] == 0) begin
                first++;
            end
        end else begin
            first = DIGITS - flen;
        end
        point = DIGITS - places;

        if (neg) begin
            codes.push_back(CH_MINUS);
        end
        // When the first digit is at or past the point this loop is empty
        // and the run goes straight to the point.
        for (int k = first; k < point; k++) begin
            codes.push_back(CH_ZERO + 7'(digit[k]));
        end
        if (places > 0) begin
            codes.push_back(CH_POINT);
            for (int k = point; k < DIGITS; k++) begin
                codes.push_back(CH_ZERO + 7'(digit[k]));
            end
        end
        queue_run(codes);
    endfunction

    // Random items lean on the interesting corners: small values that
    // exercise zero suppression, extremes, and round powers of ten, next to
    // fully random values that toggle every bit. Field length zero is
    // favored, since suppression is the richest path.
    function automatic t_in random_item();
        t_in         item;
        int          corner [10] = '{0, 1, -1, 32767, -32768, -32767,
                                     9999, -10000, 10000, 99};
        int          scale;
        item.value = 16'($urandom);
        case ($urandom_range(0, 5))
            0, 1: item.value = 16'($urandom);
            2: item.value = 16'($urandom_range(0, 999));
            3: item.value = 16'(corner[$urandom_range(0, 9)]);
            default: begin
                scale = 1;
                for (int k = $urandom_range(0, 4); k > 0; k--) begin
                    scale = scale * 10;
                end
                item.value = 16'($urandom_range(1, 3) * scale);
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            item.value = -item.value;
        end
        item.field_length   = ($urandom_range(0, 3) == 0) ? 3'd0
                                                          : 3'($urandom_range(0, 7));
        item.decimal_places = 2'($urandom_range(0, 3));
        return item;
    endfunction

    // Sends one item. The random gap before it keeps start low; otherwise
    // start stays high straight from the previous item, so start only ever
    // gets a single assignment per clock edge. An item is taken at the
    // first edge where start is high and busy is low, and its expectation
    // is queued at that same edge. Busy is read right after the edge, so it
    // still holds the value the block saw.
    task automatic send_value(input t_in item, input string text);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (text.len() == 0) begin
            format_chars(item);
        end else begin
            queue_text(text);
        end
    endtask

    // Every strobed character must match the oldest one still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("unexpected character: code %0d last %b",
                             o_result.char_code, o_result.last);
                end
            end else begin
                if (o_result.char_code !== expected_chars[0].char_code ||
                        o_result.last !== expected_chars[0].last) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("mismatch: expected code %0d last %b, got code %0d last %b",
                                 expected_chars[0].char_code, expected_chars[0].last,
                                 o_result.char_code, o_result.last);
                    end
                end
                void'(expected_chars.pop_front());
            end
        end
    end

    // Watchdog for a block that hangs or never drains.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table and the first random phase: the sender idles rarely.
        sender_idle_pct = 9;
        for (int row = 0; row < TABLE_ROWS; row++) begin
            send_value(table_item[row], table_text[row]);
        end
        for (int n = 0; n < RANDOM_PHASE; n++) begin
            send_value(random_item(), "");
        end

        // Second phase: the sender is idle most of the time.
        sender_idle_pct = 60;
        for (int n = 0; n < RANDOM_PHASE; n++) begin
            send_value(random_item(), "");
        end

        // Last phase: items back to back with no idling at all.
        sender_idle_pct = 0;
        for (int n = 0; n < RANDOM_PHASE; n++) begin
            send_value(random_item(), "");
        end
        start <= 1'b0;

        // Let the last run drain, then watch a little longer for strays.
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sdf_pkg.sv
rtl/sdf_bcd.sv
rtl/signed_int_decimal_formatter.sv
bench/tb_signed_int_decimal_formatter.sv
